/* rtl/multi_background_color_key_matte_macros.svh */
// Assertion macros for the multi-background color key matte checker.
// Holds only macro definitions; no dependencies.
`ifndef MULTI_BACKGROUND_COLOR_KEY_MATTE_MACROS_SVH
`define MULTI_BACKGROUND_COLOR_KEY_MATTE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBCK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBCK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mbck_pkg.sv */
// Shared types and constants of the multi-background color key matte.
// No dependencies; used by every module of the block.
`default_nettype none

package mbck_pkg;

    localparam int PIX_W          = 8;
    localparam int NUM_W          = 2 * PIX_W;
    localparam int QUO_IDX_W      = $clog2(PIX_W);
    localparam int N_CH           = 3;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = PIX_W / DIV_STAGES;
    localparam int NUM_STAGES     = 2 + DIV_STAGES;
    localparam int CFG_IDX_W      = 2;

    // Color lanes of the divider.
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BLUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_RED   = 2'd2;

    localparam logic [PIX_W-1:0] KEY_BLUE_RST  = 8'd8;
    localparam logic [PIX_W-1:0] KEY_GREEN_RST = 8'd255;
    localparam logic [PIX_W-1:0] KEY_RED_RST   = 8'd19;
    localparam logic [PIX_W-1:0] PIX_MAX       = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] ref1_green;
        logic [PIX_W-1:0] ref2_green;
        logic [PIX_W-1:0] ref3_green;
        logic [PIX_W-1:0] key1_green;
        logic [PIX_W-1:0] key2_green;
        logic [PIX_W-1:0] key3_green;
        logic [PIX_W-1:0] key1_blue;
        logic [PIX_W-1:0] key1_red;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_alpha;
    } res_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [PIX_W-1:0] quo;
        logic             sat;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [N_CH-1:0] lane;
        logic [PIX_W-1:0]     alpha;
        logic                 zero;
    } div_word_t;

    typedef struct packed {
        logic [DIV_STAGES-1:0] load;
    } div_ctrl_t;

endpackage

`default_nettype wire

/* rtl/multi_background_color_key_matte.sv */
// Top level of the multi-background color key matte: alpha and numerator
// stages, handshake control and key registers. Depends on mbck_pkg, mbck_div.
//
// Usage: pixels enter on pix_valid / pix_stall / pix_data, one transfer per
// cycle when pix_valid is high and pix_stall is low. Results leave on
// res_valid / res_stall / res_data in the same order, one per pixel.
// The pipeline has six register stages: alpha from the green extremes, the
// three color numerators (one 8x8 multiply each), then four divider stages
// of two quotient bits each; the last divider stage is the output register.
// Throughput is one pixel per clock while the receiver does not stall.
// When the receiver stalls, results hold and empty stages behind them keep
// filling; pix_stall rises only once every stage holds a pixel.
// Key colors are written on cfg_valid / cfg_index / cfg_data; cfg_ready is
// always high and an index beyond the three keys is ignored. Keys should
// be written while no pixel is in flight.
// Reset empties the pipeline and loads the default key colors.
`default_nettype none

module multi_background_color_key_matte (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pix_valid,
    output logic                              pix_stall,
    input  wire mbck_pkg::pix_t               pix_data,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output mbck_pkg::res_t                    res_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [mbck_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbck_pkg::PIX_W-1:0]   cfg_data
);
    import mbck_pkg::*;

    logic [PIX_W-1:0]      key_blue_reg, key_green_reg, key_red_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] rdy;

    logic [PIX_W-1:0] rmax, kmin, alpha_next;
    logic [PIX_W-1:0] s1_alpha_reg, s1_blue_reg, s1_green_reg, s1_red_reg;

    div_word_t s2_word_next, s2_word_reg;
    div_ctrl_t div_ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_blue_reg  <= KEY_BLUE_RST;
            key_green_reg <= KEY_GREEN_RST;
            key_red_reg   <= KEY_RED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_BLUE:  key_blue_reg  <= cfg_data;
                CFG_KEY_GREEN: key_green_reg <= cfg_data;
                CFG_KEY_RED:   key_red_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !res_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign pix_stall     = !rdy[0];
    assign res_valid     = valid_reg[NUM_STAGES-1];
    assign div_ctrl.load = rdy[NUM_STAGES-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= pix_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: alpha = clamp(255 - min(keyed) + max(reference), 0, 255).
    // The sum can never go below zero, and when max < min it stays below 255.
    always_comb
    begin
        rmax = pix_data.ref1_green;
        if (pix_data.ref2_green > rmax)
            rmax = pix_data.ref2_green;
        if (pix_data.ref3_green > rmax)
            rmax = pix_data.ref3_green;
        kmin = pix_data.key1_green;
        if (pix_data.key2_green < kmin)
            kmin = pix_data.key2_green;
        if (pix_data.key3_green < kmin)
            kmin = pix_data.key3_green;
        if (rmax >= kmin)
            alpha_next = PIX_MAX;
        else
            alpha_next = ~kmin + rmax;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_alpha_reg <= alpha_next;
            s1_blue_reg  <= pix_data.key1_blue;
            s1_green_reg <= pix_data.key1_green;
            s1_red_reg   <= pix_data.key1_red;
        end
    end

    // Stage 2: numerator 255*c - K*(255 - A), with negative values clipped
    // to zero so the divider only sees unsigned dividends.
    function automatic logic [NUM_W-1:0] numer(logic [PIX_W-1:0] c,
                                               logic [PIX_W-1:0] k,
                                               logic [PIX_W-1:0] a);
        logic [NUM_W-1:0] pos;
        logic [NUM_W-1:0] neg;
        pos = {c, {PIX_W{1'b0}}} - NUM_W'(c);
        neg = NUM_W'(k) * NUM_W'(PIX_MAX - a);
        return (pos > neg) ? (pos - neg) : '0;
    endfunction

    always_comb
    begin
        s2_word_next.alpha = s1_alpha_reg;
        s2_word_next.zero  = (s1_alpha_reg == '0);
        s2_word_next.lane  = '0;
        s2_word_next.lane[LANE_BLUE].rem  = numer(s1_blue_reg, key_blue_reg, s1_alpha_reg);
        s2_word_next.lane[LANE_GREEN].rem = numer(s1_green_reg, key_green_reg, s1_alpha_reg);
        s2_word_next.lane[LANE_RED].rem   = numer(s1_red_reg, key_red_reg, s1_alpha_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    mbck_div u_div (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .word_in (s2_word_reg),
        .res     (res_data)
    );

endmodule

`default_nettype wire

/* rtl/mbck_div.sv */
// Pipelined restoring divider for the three color lanes, with saturation and
// zero-alpha forcing on the last stage. Depends on mbck_pkg.
`default_nettype none

module mbck_div (
    input  wire logic              clk,
    input  wire mbck_pkg::div_ctrl_t ctrl,
    input  wire mbck_pkg::div_word_t word_in,
    output mbck_pkg::res_t         res
);
    import mbck_pkg::*;

    div_word_t [DIV_STAGES-1:0] stg_reg;
    div_word_t [DIV_STAGES-1:0] stg_in;
    div_word_t [DIV_STAGES-1:0] stg_next;

    // A quotient that would exceed eight bits saturates; the remaining
    // steps then leave that lane alone.
    function automatic div_word_t sat_check(div_word_t w);
        div_word_t r;
        r = w;
        for (int l = 0; l < N_CH; l++)
        begin
            r.lane[l].sat = (w.lane[l].rem >= {w.alpha, {PIX_W{1'b0}}});
        end
        return r;
    endfunction

    function automatic div_word_t div_step(div_word_t w, int unsigned hi);
        div_word_t            r;
        logic [QUO_IDX_W-1:0] b;
        logic [NUM_W-1:0]     sh;
        r = w;
        for (int l = 0; l < N_CH; l++)
        begin
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                b  = QUO_IDX_W'(hi - j);
                sh = NUM_W'(w.alpha) << b;
                if (!r.lane[l].sat && (r.lane[l].rem >= sh))
                begin
                    r.lane[l].rem    = r.lane[l].rem - sh;
                    r.lane[l].quo[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always_comb
    begin
        stg_in[0] = sat_check(word_in);
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stg_in[s] = stg_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stg_next[s] = div_step(stg_in[s], (PIX_W - 1) - s * BITS_PER_STAGE);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (ctrl.load[s])
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    function automatic logic [PIX_W-1:0] lane_out(div_lane_t l, logic zero);
        logic [PIX_W-1:0] v;
        if (zero)
            v = '0;
        else if (l.sat)
            v = PIX_MAX;
        else
            v = l.quo;
        return v;
    endfunction

    always_comb
    begin
        res.out_blue  = lane_out(stg_reg[DIV_STAGES-1].lane[LANE_BLUE],
                                 stg_reg[DIV_STAGES-1].zero);
        res.out_green = lane_out(stg_reg[DIV_STAGES-1].lane[LANE_GREEN],
                                 stg_reg[DIV_STAGES-1].zero);
        res.out_red   = lane_out(stg_reg[DIV_STAGES-1].lane[LANE_RED],
                                 stg_reg[DIV_STAGES-1].zero);
        res.out_alpha = stg_reg[DIV_STAGES-1].alpha;
    end

endmodule

`default_nettype wire

/* rtl/mbck_checker.sv */
// Port-level checker for the multi-background color key matte, bound to the
// top level. Depends on mbck_pkg and multi_background_color_key_matte_macros.svh.
`default_nettype none
`include "multi_background_color_key_matte_macros.svh"

module mbck_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           pix_stall,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire mbck_pkg::res_t res_data
);
    import mbck_pkg::*;

    `MBCK_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid,
        "result dropped while stalled")
    `MBCK_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && res_stall, $stable(res_data),
        "stalled result changed")
    // With the output register empty, every stage can take a pixel.
    `MBCK_ASSERT_NOW(a_no_stall_empty, clk, rst_n, !res_valid, !pix_stall,
        "input stalled with empty output")
    `MBCK_ASSERT_NOW(a_zero_alpha, clk, rst_n, res_valid && (res_data.out_alpha == 8'd0),
        (res_data.out_blue == 8'd0) && (res_data.out_green == 8'd0) &&
        (res_data.out_red == 8'd0), "color nonzero at zero alpha")

endmodule

bind multi_background_color_key_matte mbck_checker u_mbck_checker (.*);

`default_nettype wire
